/* src/ps2sc_pkg.sv */
// ----------------------------------------------------------------------------
// ps2sc_pkg
// Shared widths, scan code constants and the key / character lookup
// functions of the PS/2 set 2 scan code decoder.
// ----------------------------------------------------------------------------
package ps2sc_pkg;

    localparam int unsigned SCAN_W = 8;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned KEY_W  = 5;

    // prefix and modifier bytes
    localparam logic [SCAN_W-1:0] SC_BREAK   = 8'hF0;
    localparam logic [SCAN_W-1:0] SC_EXT     = 8'hE0;
    localparam logic [SCAN_W-1:0] SC_LSHIFT  = 8'h12;
    localparam logic [SCAN_W-1:0] SC_RSHIFT  = 8'h59;
    localparam logic [SCAN_W-1:0] SC_CTRL    = 8'h14;
    localparam logic [SCAN_W-1:0] SC_ALT     = 8'h11;

    // arrow keys (extended)
    localparam logic [SCAN_W-1:0] SC_UP      = 8'h75;
    localparam logic [SCAN_W-1:0] SC_DOWN    = 8'h72;
    localparam logic [SCAN_W-1:0] SC_LEFT    = 8'h6B;
    localparam logic [SCAN_W-1:0] SC_RIGHT   = 8'h74;

    // function keys
    localparam logic [SCAN_W-1:0] SC_F1      = 8'h05;
    localparam logic [SCAN_W-1:0] SC_F2      = 8'h06;
    localparam logic [SCAN_W-1:0] SC_F3      = 8'h04;
    localparam logic [SCAN_W-1:0] SC_F4      = 8'h0C;
    localparam logic [SCAN_W-1:0] SC_F5      = 8'h03;
    localparam logic [SCAN_W-1:0] SC_F6      = 8'h0B;
    localparam logic [SCAN_W-1:0] SC_F7      = 8'h83;
    localparam logic [SCAN_W-1:0] SC_F8      = 8'h0A;
    localparam logic [SCAN_W-1:0] SC_F9      = 8'h01;
    localparam logic [SCAN_W-1:0] SC_F10     = 8'h09;
    localparam logic [SCAN_W-1:0] SC_F11     = 8'h78;
    localparam logic [SCAN_W-1:0] SC_F12     = 8'h07;

    // special key codes on the result
    localparam logic [KEY_W-1:0] KEY_NONE  = 5'd0;
    localparam logic [KEY_W-1:0] KEY_F1    = 5'd1;
    localparam logic [KEY_W-1:0] KEY_F2    = 5'd2;
    localparam logic [KEY_W-1:0] KEY_F3    = 5'd3;
    localparam logic [KEY_W-1:0] KEY_F4    = 5'd4;
    localparam logic [KEY_W-1:0] KEY_F5    = 5'd5;
    localparam logic [KEY_W-1:0] KEY_F6    = 5'd6;
    localparam logic [KEY_W-1:0] KEY_F7    = 5'd7;
    localparam logic [KEY_W-1:0] KEY_F8    = 5'd8;
    localparam logic [KEY_W-1:0] KEY_F9    = 5'd9;
    localparam logic [KEY_W-1:0] KEY_F10   = 5'd10;
    localparam logic [KEY_W-1:0] KEY_F11   = 5'd11;
    localparam logic [KEY_W-1:0] KEY_F12   = 5'd12;
    localparam logic [KEY_W-1:0] KEY_UP    = 5'd13;
    localparam logic [KEY_W-1:0] KEY_DOWN  = 5'd14;
    localparam logic [KEY_W-1:0] KEY_LEFT  = 5'd15;
    localparam logic [KEY_W-1:0] KEY_RIGHT = 5'd16;

    typedef logic [SCAN_W-1:0] t_scan;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [KEY_W-1:0]  t_key;

    function automatic t_key fkey_number(input t_scan sc);
        t_key k;
        unique case (sc)
            SC_F1:   k = KEY_F1;
            SC_F2:   k = KEY_F2;
            SC_F3:   k = KEY_F3;
            SC_F4:   k = KEY_F4;
            SC_F5:   k = KEY_F5;
            SC_F6:   k = KEY_F6;
            SC_F7:   k = KEY_F7;
            SC_F8:   k = KEY_F8;
            SC_F9:   k = KEY_F9;
            SC_F10:  k = KEY_F10;
            SC_F11:  k = KEY_F11;
            SC_F12:  k = KEY_F12;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic t_key arrow_number(input t_scan sc);
        t_key k;
        unique case (sc)
            SC_UP:    k = KEY_UP;
            SC_DOWN:  k = KEY_DOWN;
            SC_LEFT:  k = KEY_LEFT;
            SC_RIGHT: k = KEY_RIGHT;
            default:  k = KEY_NONE;
        endcase
        return k;
    endfunction

    // character ROM: returns {normal, shifted}, zero where no character
    function automatic logic [2*CHAR_W-1:0] char_pair(input logic [CHAR_W-1:0] idx);
        logic [2*CHAR_W-1:0] p;
        unique case (idx)
            7'h0E:   p = {7'h60, 7'h7E}; // ` ~
            7'h15:   p = {7'h71, 7'h51}; // q Q
            7'h16:   p = {7'h31, 7'h21}; // 1 !
            7'h1A:   p = {7'h7A, 7'h5A}; // z Z
            7'h1B:   p = {7'h73, 7'h53}; // s S
            7'h1C:   p = {7'h61, 7'h41}; // a A
            7'h1D:   p = {7'h77, 7'h57}; // w W
            7'h1E:   p = {7'h32, 7'h40}; // 2 @
            7'h21:   p = {7'h63, 7'h43}; // c C
            7'h22:   p = {7'h78, 7'h58}; // x X
            7'h23:   p = {7'h64, 7'h44}; // d D
            7'h24:   p = {7'h65, 7'h45}; // e E
            7'h25:   p = {7'h34, 7'h24}; // 4 $
            7'h26:   p = {7'h33, 7'h23}; // 3 #
            7'h29:   p = {7'h20, 7'h20}; // space
            7'h2A:   p = {7'h76, 7'h56}; // v V
            7'h2B:   p = {7'h66, 7'h46}; // f F
            7'h2C:   p = {7'h74, 7'h54}; // t T
            7'h2D:   p = {7'h72, 7'h52}; // r R
            7'h2E:   p = {7'h35, 7'h25}; // 5 %
            7'h31:   p = {7'h6E, 7'h4E}; // n N
            7'h32:   p = {7'h62, 7'h42}; // b B
            7'h33:   p = {7'h68, 7'h48}; // h H
            7'h34:   p = {7'h67, 7'h47}; // g G
            7'h35:   p = {7'h79, 7'h59}; // y Y
            7'h36:   p = {7'h36, 7'h5E}; // 6 ^
            7'h3A:   p = {7'h6D, 7'h4D}; // m M
            7'h3B:   p = {7'h6A, 7'h4A}; // j J
            7'h3C:   p = {7'h75, 7'h55}; // u U
            7'h3D:   p = {7'h37, 7'h26}; // 7 &
            7'h3E:   p = {7'h38, 7'h2A}; // 8 *
            7'h41:   p = {7'h2C, 7'h3C}; // , <
            7'h42:   p = {7'h6B, 7'h4B}; // k K
            7'h43:   p = {7'h69, 7'h49}; // i I
            7'h44:   p = {7'h6F, 7'h4F}; // o O
            7'h45:   p = {7'h30, 7'h29}; // 0 )
            7'h46:   p = {7'h39, 7'h28}; // 9 (
            7'h49:   p = {7'h2E, 7'h3E}; // . >
            7'h4A:   p = {7'h2F, 7'h3F}; // / ?
            7'h4B:   p = {7'h6C, 7'h4C}; // l L
            7'h4C:   p = {7'h3B, 7'h3A}; // ; :
            7'h4D:   p = {7'h70, 7'h50}; // p P
            7'h4E:   p = {7'h2D, 7'h5F}; // - _
            7'h52:   p = {7'h27, 7'h22}; // ' "
            7'h54:   p = {7'h5B, 7'h7B}; // [ {
            7'h55:   p = {7'h3D, 7'h2B}; // = +
            7'h5A:   p = {7'h0A, 7'h0A}; // enter
            7'h5B:   p = {7'h5D, 7'h7D}; // ] }
            7'h5D:   p = {7'h5C, 7'h7C}; // \ |
            7'h66:   p = {7'h08, 7'h08}; // backspace
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

/* src/ps2sc_if.sv */
// ----------------------------------------------------------------------------
// ps2sc_in_if / ps2sc_out_if
// Valid/ready channels carrying scan bytes in and decoded key items out.
// ----------------------------------------------------------------------------
interface ps2sc_in_if;
    logic                        valid;
    logic                        ready;
    logic [ps2sc_pkg::SCAN_W-1:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

interface ps2sc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        char_valid;
    logic [ps2sc_pkg::CHAR_W-1:0] char_code;
    logic [ps2sc_pkg::KEY_W-1:0]  special_key;
    logic                        shift_held;
    logic                        ctrl_held;
    logic                        alt_held;

    modport source (output valid, output char_valid, output char_code,
                    output special_key, output shift_held, output ctrl_held,
                    output alt_held, input ready);
    modport sink   (input valid, input char_valid, input char_code,
                    input special_key, input shift_held, input ctrl_held,
                    input alt_held, output ready);
endinterface

/* src/ps2_scan_code_to_ascii_top.sv */
// ----------------------------------------------------------------------------
// ps2_scan_code_to_ascii_top
// PS/2 set 2 scan byte decoder: tracks break/extended prefixes and the
// shift, ctrl and alt levels, and reports characters, F-keys and arrows.
// ----------------------------------------------------------------------------
// Path from byte accepted to result valid: input register, then result
// register after the flag update and character ROM lookup.
// Throughput: one item per cycle; a stalled result holds the input register,
// so intake stops once that register is full.
// Reset: synchronous, active low; clears both prefix flags, the modifier
// levels and the valid bits of both stages.
module ps2_scan_code_to_ascii_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ps2sc_in_if.sink           i_in,
    ps2sc_out_if.source        o_out
);

    // stage 1: input register
    logic                   r_in_valid;
    ps2sc_pkg::t_scan       r_scan;

    // decoder state
    logic r_release, r_extended, r_shift, r_ctrl, r_alt;
    logic n_release, n_extended, n_shift, n_ctrl, n_alt;

    // stage 2: result register
    logic                   r_out_valid;
    ps2sc_pkg::t_char       r_char;
    ps2sc_pkg::t_key        r_key;
    logic                   r_shift_o, r_ctrl_o, r_alt_o;

    logic                   s2_free;
    logic                   s1_move;
    logic                   is_break, is_ext, is_shift, is_ctrl, is_alt;
    logic                   is_plain_make;
    logic [2*ps2sc_pkg::CHAR_W-1:0] pair;
    ps2sc_pkg::t_char       n_char;
    ps2sc_pkg::t_key        n_key;

    assign s2_free  = !r_out_valid || o_out.ready;
    assign s1_move  = r_in_valid && s2_free;
    assign i_in.ready = !r_in_valid || s2_free;

    always_comb begin
        is_break = (r_scan == ps2sc_pkg::SC_BREAK);
        is_ext   = (r_scan == ps2sc_pkg::SC_EXT);
        is_shift = (r_scan == ps2sc_pkg::SC_LSHIFT) || (r_scan == ps2sc_pkg::SC_RSHIFT);
        is_ctrl  = (r_scan == ps2sc_pkg::SC_CTRL);
        is_alt   = (r_scan == ps2sc_pkg::SC_ALT);

        // a prefix arms its own flag and keeps the other; anything else clears both
        n_release  = is_break || (is_ext && r_release);
        n_extended = is_ext || (is_break && r_extended);
        n_shift    = is_shift ? !r_release : r_shift;
        n_ctrl     = is_ctrl  ? !r_release : r_ctrl;
        n_alt      = is_alt   ? !r_release : r_alt;

        is_plain_make = !is_break && !is_ext && !is_shift && !is_ctrl && !is_alt
                        && !r_release;

        pair   = ps2sc_pkg::char_pair(r_scan[ps2sc_pkg::CHAR_W-1:0]);
        n_char = '0;
        n_key  = ps2sc_pkg::KEY_NONE;
        if (is_plain_make) begin
            if (r_extended) begin
                n_key = ps2sc_pkg::arrow_number(r_scan);
            end else begin
                n_key = ps2sc_pkg::fkey_number(r_scan);
                // top half of the code space has no character
                if (!r_scan[ps2sc_pkg::SCAN_W-1]) begin
                    n_char = r_shift ? pair[ps2sc_pkg::CHAR_W-1:0]
                                     : pair[2*ps2sc_pkg::CHAR_W-1:ps2sc_pkg::CHAR_W];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_release   <= 1'b0;
            r_extended  <= 1'b0;
            r_shift     <= 1'b0;
            r_ctrl      <= 1'b0;
            r_alt       <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (s2_free) begin
                r_out_valid <= r_in_valid;
            end
            if (s1_move) begin
                r_release  <= n_release;
                r_extended <= n_extended;
                r_shift    <= n_shift;
                r_ctrl     <= n_ctrl;
                r_alt      <= n_alt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_scan <= i_in.scan_code;
        end
        if (s1_move) begin
            r_char    <= n_char;
            r_key     <= n_key;
            r_shift_o <= n_shift;
            r_ctrl_o  <= n_ctrl;
            r_alt_o   <= n_alt;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.char_valid  = (r_char != '0);
    assign o_out.char_code   = r_char;
    assign o_out.special_key = r_key;
    assign o_out.shift_held  = r_shift_o;
    assign o_out.ctrl_held   = r_ctrl_o;
    assign o_out.alt_held    = r_alt_o;

endmodule

/* bench/ps2_scan_code_to_ascii_top_test.sv */
// ----------------------------------------------------------------------------
// ps2_scan_code_to_ascii_top_test
// Self-checking bench for the PS/2 set 2 scan byte decoder. A short table of
// hand-picked bytes is followed by random keystroke sequences: taps,
// modifier presses, F-keys, arrows, broken prefixes and raw noise. Both
// channels idle and stall at random. Every result is checked against a
// behavioural decoder held in the bench, or against the table for typed probes.
// ----------------------------------------------------------------------------
module ps2_scan_code_to_ascii_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HALF_PERIOD  = 4;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned BYTE_TARGET  = 800;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SHOW_LIMIT   = 10;
    localparam int unsigned N_PROBES     = 25;
    localparam int unsigned N_CHARS      = 50;

    typedef struct packed {
        logic             char_valid;
        ps2sc_pkg::t_char char_code;
        ps2sc_pkg::t_key  special_key;
        logic             shift_held;
        logic             ctrl_held;
        logic             alt_held;
    } t_key_result;

    typedef struct packed {
        ps2sc_pkg::t_scan code;
        logic             typed;
        t_key_result      want;
    } t_probe;

    localparam t_key_result RES_IDLE = '0;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             feed_valid = 1'b0;
    ps2sc_pkg::t_scan feed_code  = '0;
    logic             sink_ready = 1'b0;

    ps2sc_in_if  in_if ();
    ps2sc_out_if out_if ();

    assign in_if.valid     = feed_valid;
    assign in_if.scan_code = feed_code;
    assign out_if.ready    = sink_ready;

    ps2_scan_code_to_ascii_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // scan codes that carry a character, with the unshifted and shifted
    // character at the same position in the two strings
    ps2sc_pkg::t_scan char_scan [N_CHARS] = '{
        8'h0E, 8'h15, 8'h16, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E,
        8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h29, 8'h2A,
        8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h31, 8'h32, 8'h33, 8'h34,
        8'h35, 8'h36, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h41,
        8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h49, 8'h4A, 8'h4B,
        8'h4C, 8'h4D, 8'h4E, 8'h52, 8'h54, 8'h55, 8'h5A, 8'h5B,
        8'h5D, 8'h66
    };
    string plain_chars   = "`q1zsaw2cxde43 vftr5nbhgy6mju78,kio09./l;p-'[=\n]\\\010";
    string shifted_chars = "~Q!ZSAW@CXDE$# VFTR%NBHGY^MJU&*<KIO)(>?L:P_\"{+\n}|\010";

    ps2sc_pkg::t_scan mod_codes [4] = '{
        ps2sc_pkg::SC_LSHIFT, ps2sc_pkg::SC_RSHIFT, ps2sc_pkg::SC_CTRL, ps2sc_pkg::SC_ALT
    };
    ps2sc_pkg::t_scan arrow_codes [4] = '{
        ps2sc_pkg::SC_UP, ps2sc_pkg::SC_DOWN, ps2sc_pkg::SC_LEFT, ps2sc_pkg::SC_RIGHT
    };
    ps2sc_pkg::t_scan fkey_codes [12] = '{
        ps2sc_pkg::SC_F1, ps2sc_pkg::SC_F2, ps2sc_pkg::SC_F3, ps2sc_pkg::SC_F4,
        ps2sc_pkg::SC_F5, ps2sc_pkg::SC_F6, ps2sc_pkg::SC_F7, ps2sc_pkg::SC_F8,
        ps2sc_pkg::SC_F9, ps2sc_pkg::SC_F10, ps2sc_pkg::SC_F11, ps2sc_pkg::SC_F12
    };

    t_probe probes [N_PROBES] = '{
        '{8'h00, 1'b1, RES_IDLE},
        '{8'hFF, 1'b1, RES_IDLE},
        '{ps2sc_pkg::SC_F7, 1'b1,
          '{1'b0, 7'h00, ps2sc_pkg::KEY_F7, 1'b0, 1'b0, 1'b0}},
        '{8'h1C, 1'b1,
          '{1'b1, 7'h61, ps2sc_pkg::KEY_NONE, 1'b0, 1'b0, 1'b0}},
        '{ps2sc_pkg::SC_LSHIFT, 1'b1,
          '{1'b0, 7'h00, ps2sc_pkg::KEY_NONE, 1'b1, 1'b0, 1'b0}},
        '{8'h1C, 1'b1,
          '{1'b1, 7'h41, ps2sc_pkg::KEY_NONE, 1'b1, 1'b0, 1'b0}},
        '{8'h0E,                1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_BREAK,  1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_LSHIFT, 1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_RSHIFT, 1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_CTRL,   1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_ALT,    1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_EXT,    1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_UP,     1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_EXT,    1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_BREAK,  1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_LEFT,   1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_EXT,    1'b0, RES_IDLE},
        '{8'h1C,                1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_F11,    1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_BREAK,  1'b0, RES_IDLE},
        '{8'h66,                1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_BREAK,  1'b0, RES_IDLE},
        '{ps2sc_pkg::SC_CTRL,   1'b0, RES_IDLE},
        '{8'h5A,                1'b0, RES_IDLE}
    };

    // decoder state
    logic brk_armed;
    logic ext_armed;
    logic shift_dn;
    logic ctrl_dn;
    logic alt_dn;

    t_key_result expected_q [$];

    int unsigned cycle_count;
    int unsigned stall_left;
    int unsigned bytes_sent;
    int unsigned results_seen;
    int unsigned chars_seen;
    int unsigned keys_seen;
    int unsigned fail_count;

    function automatic ps2sc_pkg::t_key fkey_of(input ps2sc_pkg::t_scan code);
        ps2sc_pkg::t_key k;
        k = ps2sc_pkg::KEY_NONE;
        for (int i = 0; i < 12; i++) begin
            if (fkey_codes[i] == code) k = ps2sc_pkg::KEY_F1 + ps2sc_pkg::t_key'(i);
        end
        return k;
    endfunction

    function automatic ps2sc_pkg::t_key arrow_of(input ps2sc_pkg::t_scan code);
        ps2sc_pkg::t_key k;
        k = ps2sc_pkg::KEY_NONE;
        for (int i = 0; i < 4; i++) begin
            if (arrow_codes[i] == code) k = ps2sc_pkg::KEY_UP + ps2sc_pkg::t_key'(i);
        end
        return k;
    endfunction

    function automatic logic [7:0] char_of(input ps2sc_pkg::t_scan code,
                                           input logic shifted);
        logic [7:0] ch;
        ch = 8'h00;
        for (int i = 0; i < N_CHARS; i++) begin
            if (char_scan[i] == code) ch = shifted ? shifted_chars[i] : plain_chars[i];
        end
        return ch;
    endfunction

    // advances the decoder state by one byte and returns its result
    function automatic t_key_result decode_scan(input ps2sc_pkg::t_scan code);
        t_key_result r;
        logic [7:0]  ch;
        r  = RES_IDLE;
        ch = 8'h00;
        if (code == ps2sc_pkg::SC_BREAK) begin
            brk_armed = 1'b1;
        end else if (code == ps2sc_pkg::SC_EXT) begin
            ext_armed = 1'b1;
        end else begin
            if (code == ps2sc_pkg::SC_LSHIFT || code == ps2sc_pkg::SC_RSHIFT) begin
                shift_dn = !brk_armed;
            end else if (code == ps2sc_pkg::SC_CTRL) begin
                ctrl_dn = !brk_armed;
            end else if (code == ps2sc_pkg::SC_ALT) begin
                alt_dn = !brk_armed;
            end else if (!brk_armed) begin
                if (ext_armed) begin
                    r.special_key = arrow_of(code);
                end else begin
                    r.special_key = fkey_of(code);
                    // top half of the code space has no table entry
                    if (!code[ps2sc_pkg::SCAN_W-1]) ch = char_of(code, shift_dn);
                end
            end
            brk_armed = 1'b0;
            ext_armed = 1'b0;
        end
        r.char_valid = (ch != 8'h00);
        r.char_code  = ch[6:0];
        r.shift_held = shift_dn;
        r.ctrl_held  = ctrl_dn;
        r.alt_held   = alt_dn;
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        return (r < 85) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    endfunction

    function automatic logic calm();
        return (cycle_count % 1500) < 250;
    endfunction

    // called just after a rising edge; returns at the edge that takes the item
    task automatic send_scan(input ps2sc_pkg::t_scan code, input logic typed,
                             input t_key_result want);
        int unsigned gap;
        t_key_result predicted;
        gap = (calm() || $urandom_range(0, 99) < 60) ? 0 : idle_len();
        if (gap != 0) begin
            feed_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        feed_valid <= 1'b1;
        feed_code  <= code;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = decode_scan(code);
        expected_q.push_back(typed ? want : predicted);
        bytes_sent++;
    endtask

    task automatic press_key(input ps2sc_pkg::t_scan code, input logic extended,
                             input logic released);
        if (extended) send_scan(ps2sc_pkg::SC_EXT, 1'b0, RES_IDLE);
        if (released) send_scan(ps2sc_pkg::SC_BREAK, 1'b0, RES_IDLE);
        send_scan(code, 1'b0, RES_IDLE);
    endtask

    task automatic note_failure(input string what, input t_key_result want,
                                input t_key_result got);
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
            $display("[%0t] %s: expected cv=%0b ch=%02h key=%0d sca=%b%b%b",
                     $realtime, what,
                     want.char_valid, want.char_code, want.special_key,
                     want.shift_held, want.ctrl_held, want.alt_held);
            $display("    got cv=%0b ch=%02h key=%0d sca=%b%b%b",
                     got.char_valid, got.char_code, got.special_key,
                     got.shift_held, got.ctrl_held, got.alt_held);
        end
    endtask

    // output back-pressure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (stall_left != 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm() && $urandom_range(0, 99) < 25) begin
            sink_ready <= 1'b0;
            stall_left <= idle_len() - 1;
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_key_result got;
        t_key_result want;
        if (i_rst_n && out_if.valid && sink_ready) begin
            got = '{out_if.char_valid, out_if.char_code, out_if.special_key,
                    out_if.shift_held, out_if.ctrl_held, out_if.alt_held};
            results_seen++;
            if (got.char_valid) chars_seen++;
            if (got.special_key != ps2sc_pkg::KEY_NONE) keys_seen++;
            if (expected_q.size() == 0) begin
                note_failure("unexpected item", RES_IDLE, got);
            end else begin
                want = expected_q.pop_front();
                if (got.char_valid !== want.char_valid ||
                    got.char_code !== want.char_code ||
                    got.special_key !== want.special_key ||
                    got.shift_held !== want.shift_held ||
                    got.ctrl_held !== want.ctrl_held ||
                    got.alt_held !== want.alt_held) begin
                    note_failure("mismatch", want, got);
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timed out after %0d cycles, %0d items outstanding",
                 CYCLE_LIMIT, expected_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        ps2sc_pkg::t_scan code;
        int unsigned pick;
        brk_armed = 1'b0;
        ext_armed = 1'b0;
        shift_dn  = 1'b0;
        ctrl_dn   = 1'b0;
        alt_dn    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_PROBES; i++) begin
            send_scan(probes[i].code, probes[i].typed, probes[i].want);
        end

        while (bytes_sent < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                code = char_scan[$urandom_range(0, N_CHARS - 1)];
                press_key(code, 1'b0, 1'b0);
                if ($urandom_range(0, 9) < 7) press_key(code, 1'b0, 1'b1);
            end else if (pick < 52) begin
                press_key(mod_codes[$urandom_range(0, 3)], $urandom_range(0, 5) == 0,
                          1'($urandom_range(0, 1)));
            end else if (pick < 62) begin
                code = fkey_codes[$urandom_range(0, 11)];
                press_key(code, 1'b0, 1'b0);
                if ($urandom_range(0, 1) != 0) press_key(code, 1'b0, 1'b1);
            end else if (pick < 74) begin
                press_key(arrow_codes[$urandom_range(0, 3)], 1'b1,
                          $urandom_range(0, 3) == 0);
            end else if (pick < 80) begin
                // extended prefix on a random byte, which need not be an arrow
                press_key(ps2sc_pkg::t_scan'($urandom_range(0, 255)), 1'b1,
                          1'($urandom_range(0, 1)));
            end else if (pick < 88) begin
                // dangling or doubled prefixes
                repeat ($urandom_range(1, 3)) begin
                    send_scan(($urandom_range(0, 1) != 0) ? ps2sc_pkg::SC_BREAK
                                                         : ps2sc_pkg::SC_EXT,
                              1'b0, RES_IDLE);
                end
            end else begin
                send_scan(ps2sc_pkg::t_scan'($urandom_range(0, 255)), 1'b0, RES_IDLE);
            end
        end
        feed_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d scan bytes and checked %0d results in %0d cycles",
                 bytes_sent, results_seen, cycle_count);
        $display("Results carried %0d characters and %0d F-key/arrow reports; %0d failures",
                 chars_seen, keys_seen, fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
